// ===== hw/rtl/ppu_pkg.sv =====
// shared types, codes and constants of the particle pool update engine
package ppu_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int SLOT_W    = 6;
    localparam int DIV_STEPS = 40;

    localparam logic [1:0] CMD_SPAWN = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_EMIT  = 2'd3;

    localparam logic [1:0] KIND_SPAWN = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_REC   = 2'd2;

    localparam logic [1:0] CFG_GRAVITY   = 2'd0;
    localparam logic [1:0] CFG_MIN_SIZE  = 2'd1;
    localparam logic [1:0] CFG_MIN_ALPHA = 2'd2;

    localparam logic [22:0] GRAVITY_RST   = 23'd642253;
    localparam logic [15:0] MIN_SIZE_RST  = 16'd66;
    localparam logic [7:0]  MIN_ALPHA_RST = 8'd3;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [23:0]        life;
        logic [23:0]        max_life;
        logic [15:0]        size;
        logic [31:0]        color;
        logic [3:0]         kind;
    } t_part;

    typedef enum logic [2:0] {
        RES_SPAWN_OK = 3'd0,
        RES_FULL     = 3'd1,
        RES_COUNT    = 3'd2,
        RES_TRAILER  = 3'd3,
        RES_REC      = 3'd4
    } t_res;

    typedef struct packed {
        logic              lat;
        logic [SLOT_W-1:0] idx;
        logic              pass;
        logic              clear_all;
        logic              spawn_wr;
        logic              ram_re;
        logic              cur_ld;
        logic              free;
        logic              mul;
        logic              acc;
        logic [1:0]        ph;
        logic              wr_back;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              tot_load;
        logic              sc_load;
        logic              sc_step;
        logic              sc_fin;
        logic              ssel;
        logic              put;
        t_res              res;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic life_le_dt;
        logic kind_match;
        logic bypass;
        logic div_last;
        logic visible;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ppu_ram.sv =====
// generic single write port ram with registered read
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ppu_ctrl.sv =====
// controller state machine of the particle pool update engine
module ppu_ctrl #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_cmd,
    output logic          o_in_stall,
    input  ppu_pkg::t_sts i_sts,
    output ppu_pkg::t_cmd o_cmd
);
    localparam int IW = $clog2(SLOTS);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SSCAN = 14'b00000000000010,
        S_TSCAN = 14'b00000000000100,
        S_TLD   = 14'b00000000001000,
        S_TMUL  = 14'b00000000010000,
        S_TACC  = 14'b00000000100000,
        S_TWR   = 14'b00000001000000,
        S_ESCAN = 14'b00000010000000,
        S_ELD   = 14'b00000100000000,
        S_ESL   = 14'b00001000000000,
        S_ESD   = 14'b00010000000000,
        S_ESF   = 14'b00100000000000,
        S_ECHK  = 14'b01000000000000,
        S_PUT   = 14'b10000000000000
    } t_state;

    t_state          r_st, n_st;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_pass, n_pass;
    logic            r_emit, n_emit;
    logic [1:0]      r_ph, n_ph;
    logic            r_ssel, n_ssel;
    ppu_pkg::t_res   r_res, n_res;
    ppu_pkg::t_cmd   c;
    logic            adv;
    logic            last_idx;

    assign last_idx   = (r_idx == IW'(SLOTS - 1));
    assign o_in_stall = (r_st != S_IDLE);
    assign o_cmd      = c;

    always_comb begin
        n_st   = r_st;
        n_idx  = r_idx;
        n_pass = r_pass;
        n_emit = r_emit;
        n_ph   = r_ph;
        n_ssel = r_ssel;
        n_res  = r_res;
        adv    = 1'b0;
        c      = '0;
        c.idx  = ppu_pkg::SLOT_W'(r_idx);
        c.pass = r_pass;
        c.ph   = r_ph;
        c.ssel = r_ssel;
        c.res  = r_res;
        unique case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.lat     = 1'b1;
                    c.cnt_clr = 1'b1;
                    n_idx     = '0;
                    n_pass    = 1'b0;
                    unique case (i_cmd)
                        ppu_pkg::CMD_SPAWN: n_st = S_SSCAN;
                        ppu_pkg::CMD_TICK: begin
                            n_emit = 1'b0;
                            n_st   = S_TSCAN;
                        end
                        ppu_pkg::CMD_CLEAR: begin
                            c.clear_all = 1'b1;
                            n_res       = ppu_pkg::RES_COUNT;
                            n_st        = S_PUT;
                        end
                        ppu_pkg::CMD_EMIT: begin
                            n_emit = 1'b1;
                            n_st   = S_ESCAN;
                        end
                    endcase
                end
            end
            S_SSCAN: begin
                if (!i_sts.act) begin
                    c.spawn_wr = 1'b1;
                    n_res      = ppu_pkg::RES_SPAWN_OK;
                    n_st       = S_PUT;
                end else if (last_idx) begin
                    n_res = ppu_pkg::RES_FULL;
                    n_st  = S_PUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TSCAN: begin
                if (i_sts.act) begin
                    c.ram_re = 1'b1;
                    n_st     = S_TLD;
                end else begin
                    adv = 1'b1;
                end
            end
            S_TLD: begin
                c.cur_ld = 1'b1;
                if (i_sts.life_le_dt) begin
                    c.free = 1'b1;
                    adv    = 1'b1;
                end else begin
                    n_ph = 2'd0;
                    n_st = S_TMUL;
                end
            end
            S_TMUL: begin
                c.mul = 1'b1;
                n_st  = S_TACC;
            end
            S_TACC: begin
                c.acc = 1'b1;
                if (r_ph == 2'd3) begin
                    n_st = S_TWR;
                end else begin
                    n_ph = r_ph + 2'd1;
                    n_st = S_TMUL;
                end
            end
            S_TWR: begin
                c.wr_back = 1'b1;
                c.cnt_inc = 1'b1;
                adv       = 1'b1;
            end
            S_ESCAN: begin
                if (i_sts.act) begin
                    c.ram_re = 1'b1;
                    n_st     = S_ELD;
                end else begin
                    adv = 1'b1;
                end
            end
            S_ELD: begin
                c.cur_ld = 1'b1;
                if (!i_sts.kind_match) begin
                    adv = 1'b1;
                end else begin
                    n_ssel = 1'b0;
                    n_st   = S_ESL;
                end
            end
            S_ESL: begin
                c.sc_load = 1'b1;
                n_st      = i_sts.bypass ? S_ESF : S_ESD;
            end
            S_ESD: begin
                c.sc_step = 1'b1;
                if (i_sts.div_last) begin
                    n_st = S_ESF;
                end
            end
            S_ESF: begin
                c.sc_fin = 1'b1;
                if (!r_ssel) begin
                    n_ssel = 1'b1;
                    n_st   = S_ESL;
                end else begin
                    n_st = S_ECHK;
                end
            end
            S_ECHK: begin
                if (i_sts.visible) begin
                    c.cnt_inc = 1'b1;
                    n_res     = ppu_pkg::RES_REC;
                    n_st      = S_PUT;
                end else begin
                    adv = 1'b1;
                end
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    c.put = 1'b1;
                    if (r_res == ppu_pkg::RES_REC) begin
                        adv = 1'b1;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase

        if (adv) begin
            if (last_idx) begin
                if (r_emit) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_idx  = '0;
                        n_st   = S_ESCAN;
                    end else begin
                        n_res = ppu_pkg::RES_TRAILER;
                        n_st  = S_PUT;
                    end
                end else begin
                    c.tot_load = 1'b1;
                    n_res      = ppu_pkg::RES_COUNT;
                    n_st       = S_PUT;
                end
            end else begin
                n_idx = r_idx + 1'b1;
                n_st  = r_emit ? S_ESCAN : S_TSCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_idx  <= '0;
            r_pass <= 1'b0;
            r_emit <= 1'b0;
            r_ph   <= 2'd0;
            r_ssel <= 1'b0;
            r_res  <= ppu_pkg::RES_COUNT;
        end else begin
            r_st   <= n_st;
            r_idx  <= n_idx;
            r_pass <= n_pass;
            r_emit <= n_emit;
            r_ph   <= n_ph;
            r_ssel <= n_ssel;
            r_res  <= n_res;
        end
    end
endmodule

// ===== hw/rtl/ppu_dp.sv =====
// datapath: slot store, integrator, life scaler and result register
module ppu_dp #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppu_pkg::t_cmd      i_cmd,
    output ppu_pkg::t_sts      o_sts,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic [23:0]        i_life_time,
    input  logic [15:0]        i_base_size,
    input  logic [31:0]        i_color_rgba,
    input  logic [3:0]         i_kind_flags,
    input  logic [15:0]        i_dt,
    input  logic [22:0]        i_gravity,
    input  logic [15:0]        i_min_size,
    input  logic [7:0]         i_min_alpha,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_out_kind,
    output logic               o_accepted,
    output logic [5:0]         o_live_total,
    output logic [5:0]         o_slot,
    output logic               o_is_geometric,
    output logic signed [31:0] o_at_x,
    output logic signed [31:0] o_at_y,
    output logic signed [31:0] o_at_z,
    output logic [15:0]        o_draw_size,
    output logic [31:0]        o_draw_color,
    output logic               o_last
);
    localparam int IW = $clog2(SLOTS);
    localparam int PW = $bits(ppu_pkg::t_part);

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [IW-1:0]      idx;
    ppu_pkg::t_part     r_in, r_cur, q, spawn_rec, wb_rec;
    logic [15:0]        r_dt;
    logic [SLOTS-1:0]   r_act;
    logic [5:0]         r_total, r_cnt;
    logic signed [32:0] mul_a;
    logic signed [49:0] mul_p, r_prod;
    logic signed [33:0] sh;
    logic signed [34:0] sum_px, sum_py, sum_pz, dif_vy;
    logic [15:0]        sv, sres;
    logic               sflag;
    logic [39:0]        sprod, r_num;
    logic [23:0]        r_rem;
    logic [24:0]        rem_sh;
    logic               ge;
    logic [5:0]         r_dcnt;
    logic [7:0]         r_alpha;
    logic [15:0]        r_size;
    logic               r_ov;

    assign idx = i_cmd.idx[IW-1:0];

    // slot store
    always_comb begin
        spawn_rec          = r_in;
        wb_rec             = r_cur;
        wb_rec.life        = r_cur.life - 24'(r_dt);
    end

    ppu_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.spawn_wr | i_cmd.wr_back),
        .i_waddr (idx),
        .i_wdata (i_cmd.spawn_wr ? spawn_rec : wb_rec),
        .i_re    (i_cmd.ram_re),
        .i_raddr (idx),
        .o_rdata (q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat) begin
            r_in.px       <= i_pos_x;
            r_in.py       <= i_pos_y;
            r_in.pz       <= i_pos_z;
            r_in.vx       <= i_vel_x;
            r_in.vy       <= i_vel_y;
            r_in.vz       <= i_vel_z;
            r_in.life     <= i_life_time;
            r_in.max_life <= i_life_time;
            r_in.size     <= i_base_size;
            r_in.color    <= i_color_rgba;
            r_in.kind     <= i_kind_flags;
            r_dt          <= i_dt;
        end
    end

    // integrator: one product per step, x y z then gravity
    always_comb begin
        unique case (i_cmd.ph)
            2'd0:    mul_a = 33'(r_cur.vx);
            2'd1:    mul_a = 33'(r_cur.vy);
            2'd2:    mul_a = 33'(r_cur.vz);
            default: mul_a = $signed({10'b0, i_gravity});
        endcase
        mul_p  = mul_a * $signed({1'b0, r_dt});
        sh     = r_prod[49:16];
        sum_px = 35'(r_cur.px) + 35'(sh);
        sum_py = 35'(r_cur.py) + 35'(sh);
        sum_pz = 35'(r_cur.pz) + 35'(sh);
        dif_vy = 35'(r_cur.vy) - 35'(sh);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= q;
        end else if (i_cmd.acc) begin
            unique case (i_cmd.ph)
                2'd0: r_cur.px <= sat35(sum_px);
                2'd1: r_cur.py <= sat35(sum_py);
                2'd2: r_cur.pz <= sat35(sum_pz);
                default: begin
                    if (r_cur.kind[1]) begin
                        r_cur.vy <= sat35(dif_vy);
                    end
                end
            endcase
        end
    end

    // life scaler: product then restoring division, one bit a cycle
    always_comb begin
        sv     = i_cmd.ssel ? r_cur.size : {8'b0, r_cur.color[7:0]};
        sflag  = i_cmd.ssel ? r_cur.kind[3] : r_cur.kind[2];
        sprod  = sv * r_cur.life;
        rem_sh = {r_rem, r_num[39]};
        ge     = (rem_sh >= {1'b0, r_cur.max_life});
        if (o_sts.bypass || r_num > 40'(sv)) begin
            sres = sv;
        end else begin
            sres = r_num[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_load) begin
            r_num  <= sprod;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.sc_step) begin
            r_num  <= {r_num[38:0], ge};
            r_rem  <= ge ? 24'(rem_sh - {1'b0, r_cur.max_life}) : rem_sh[23:0];
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (i_cmd.sc_fin) begin
            if (i_cmd.ssel) begin
                r_size <= sres;
            end else begin
                r_alpha <= sres[7:0];
            end
        end
    end

    // slot flags and counts; the tick total takes the count of the final slot too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= '0;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                r_act <= '0;
            end else if (i_cmd.spawn_wr) begin
                r_act[idx] <= 1'b1;
            end else if (i_cmd.free) begin
                r_act[idx] <= 1'b0;
            end
            if (i_cmd.clear_all) begin
                r_total <= '0;
            end else if (i_cmd.spawn_wr) begin
                r_total <= r_total + 6'd1;
            end else if (i_cmd.tot_load) begin
                r_total <= r_cnt + 6'(i_cmd.cnt_inc);
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.put) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            o_accepted     <= 1'b0;
            o_live_total   <= r_total;
            o_slot         <= '0;
            o_is_geometric <= 1'b0;
            o_at_x         <= '0;
            o_at_y         <= '0;
            o_at_z         <= '0;
            o_draw_size    <= '0;
            o_draw_color   <= '0;
            o_last         <= 1'b1;
            o_out_kind     <= ppu_pkg::KIND_COUNT;
            unique case (i_cmd.res)
                ppu_pkg::RES_SPAWN_OK: begin
                    o_out_kind <= ppu_pkg::KIND_SPAWN;
                    o_accepted <= 1'b1;
                    o_slot     <= 6'(idx);
                end
                ppu_pkg::RES_FULL: o_out_kind <= ppu_pkg::KIND_SPAWN;
                ppu_pkg::RES_TRAILER: o_live_total <= r_cnt;
                ppu_pkg::RES_REC: begin
                    o_out_kind     <= ppu_pkg::KIND_REC;
                    o_slot         <= 6'(idx);
                    o_is_geometric <= i_cmd.pass;
                    o_at_x         <= r_cur.px;
                    o_at_y         <= r_cur.py;
                    o_at_z         <= r_cur.pz;
                    o_draw_size    <= r_size;
                    o_draw_color   <= {r_cur.color[31:8], r_alpha};
                    o_last         <= 1'b0;
                end
                default: o_out_kind <= ppu_pkg::KIND_COUNT;
            endcase
        end
    end

    assign o_out_valid = r_ov;

    always_comb begin
        o_sts.act        = r_act[idx];
        o_sts.life_le_dt = (q.life <= 24'(r_dt));
        o_sts.kind_match = (q.kind[0] == i_cmd.pass);
        o_sts.bypass     = !sflag || (r_cur.max_life == 24'd0);
        o_sts.div_last   = (r_dcnt == 6'(ppu_pkg::DIV_STEPS - 1));
        o_sts.visible    = (r_size >= i_min_size) && (r_alpha >= i_min_alpha);
        o_sts.out_free   = !r_ov || !i_out_stall;
    end
endmodule

// ===== hw/rtl/particle_pool_update_engine_top.sv =====
// particle pool update engine: spawn takes the first free slot, clear empties the pool
// tick: walks every slot, integrates each live one and frees the ones that expire
// emit: 2 passes over the slots, up to two 40-step divisions per listed slot,
// plus the trailer; one request at a time
// reset (i_rst_n low, synchronous): slot flags, count and output valid cleared,
// registers back to defaults; the slot store is not cleared
module particle_pool_update_engine_top #(
    parameter int PARTICLE_SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic [23:0]        i_life_time,
    input  logic [15:0]        i_base_size,
    input  logic [31:0]        i_color_rgba,
    input  logic [3:0]         i_kind_flags,
    input  logic [15:0]        i_dt,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_out_kind,
    output logic               o_accepted,
    output logic [5:0]         o_live_total,
    output logic [5:0]         o_slot,
    output logic               o_is_geometric,
    output logic signed [31:0] o_at_x,
    output logic signed [31:0] o_at_y,
    output logic signed [31:0] o_at_z,
    output logic [15:0]        o_draw_size,
    output logic [31:0]        o_draw_color,
    output logic               o_last,
    // register write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data
);
    logic [22:0]   r_gravity;
    logic [15:0]   r_min_size;
    logic [7:0]    r_min_alpha;
    ppu_pkg::t_cmd cmd;
    ppu_pkg::t_sts sts;

    // register writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= ppu_pkg::GRAVITY_RST;
            r_min_size  <= ppu_pkg::MIN_SIZE_RST;
            r_min_alpha <= ppu_pkg::MIN_ALPHA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppu_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data;
                ppu_pkg::CFG_MIN_SIZE:  r_min_size  <= i_cfg_data[15:0];
                ppu_pkg::CFG_MIN_ALPHA: r_min_alpha <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer: slot scans, integrate steps, scaler steps, result hand-off
    ppu_ctrl #(.SLOTS(PARTICLE_SLOTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // slot store, integrator, life scaler and the output register
    ppu_dp #(.SLOTS(PARTICLE_SLOTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_vel_z        (i_vel_z),
        .i_life_time    (i_life_time),
        .i_base_size    (i_base_size),
        .i_color_rgba   (i_color_rgba),
        .i_kind_flags   (i_kind_flags),
        .i_dt           (i_dt),
        .i_gravity      (r_gravity),
        .i_min_size     (r_min_size),
        .i_min_alpha    (r_min_alpha),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_kind     (o_out_kind),
        .o_accepted     (o_accepted),
        .o_live_total   (o_live_total),
        .o_slot         (o_slot),
        .o_is_geometric (o_is_geometric),
        .o_at_x         (o_at_x),
        .o_at_y         (o_at_y),
        .o_at_z         (o_at_z),
        .o_draw_size    (o_draw_size),
        .o_draw_color   (o_draw_color),
        .o_last         (o_last)
    );
endmodule

// ===== hw/rtl/ppu_chk.sv =====
// port checker of the particle pool update engine and its bind
module ppu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_out_kind,
    input logic        o_accepted,
    input logic        o_last
);
    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_kind) && $stable(o_last))
        else $error("stalled result changed");

    // a taken request blocks the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // only spawn answers report a placement
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_out_kind == ppu_pkg::KIND_SPAWN)
        else $error("placement flag on non-spawn result");

    // records never close a request, everything else does
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_out_kind != ppu_pkg::KIND_REC)))
        else $error("wrong last flag");
endmodule

bind particle_pool_update_engine_top ppu_chk u_chk (.*);
